// ----- hdl/mmpc_pkg.sv -----
// ----------------------------------------------------------------------------
// mmpc_pkg
// Shared types, sizes and command codes of the minimax path cost core.
// ----------------------------------------------------------------------------
package mmpc_pkg;

	localparam int MAX_NODES = 512;
	localparam int MAX_EDGES = 16384;
	localparam int COST_BITS = 16;

	localparam int NODE_BITS = $clog2(MAX_NODES);
	localparam int EDGE_BITS = $clog2(MAX_EDGES);
	localparam int ECNT_BITS = $clog2(MAX_EDGES + 1);
	localparam int NCFG_BITS = 10;

	typedef enum logic [1:0] {
		CMD_CLEAR = 2'd0,
		CMD_ADD   = 2'd1,
		CMD_SOLVE = 2'd2,
		CMD_READ  = 2'd3
	} cmd_t;

	typedef struct packed {
		logic [1:0]           cmd;
		logic [NODE_BITS-1:0] end_a;
		logic [NODE_BITS-1:0] end_b;
		logic [COST_BITS-1:0] cost;
		logic [NODE_BITS-1:0] source_node;
		logic [NODE_BITS-1:0] read_node;
	} in_t;

	typedef struct packed {
		logic [NODE_BITS-1:0] node_index;
		logic [COST_BITS-1:0] bottleneck_cost;
		logic                 reachable;
		logic                 edge_error;
	} out_t;

	// one stored edge
	typedef struct packed {
		logic [NODE_BITS-1:0] a;
		logic [NODE_BITS-1:0] b;
		logic [COST_BITS-1:0] c;
	} edge_t;

	// one node entry: reached flag and best bottleneck so far
	typedef struct packed {
		logic                 reach;
		logic [COST_BITS-1:0] cost;
	} node_t;

endpackage

// ----- hdl/mmpc_relax.sv -----
// ----------------------------------------------------------------------------
// mmpc_relax
// Shared max/compare unit: relaxes one edge direction of the bottleneck
// distance (max along the path, min over paths).
// ----------------------------------------------------------------------------
module mmpc_relax (
	input  mmpc_pkg::node_t                  from_node,
	input  mmpc_pkg::node_t                  to_node,
	input  logic [mmpc_pkg::COST_BITS-1:0]   edge_cost,
	output logic                             improve,
	output logic [mmpc_pkg::COST_BITS-1:0]   new_cost
);
	import mmpc_pkg::*;

	// candidate is the larger of path cost and edge cost
	always_comb begin
		new_cost = (edge_cost > from_node.cost) ? edge_cost : from_node.cost;
		improve  = from_node.reach && (!to_node.reach || (new_cost < to_node.cost));
	end

endmodule

// ----- hdl/minimax_path_costs_via_spanning_tree_core.sv -----
// ----------------------------------------------------------------------------
// minimax_path_costs_via_spanning_tree_core
// Edge store plus bottleneck path solver from a source node.
// ----------------------------------------------------------------------------
//  channel | direction | handshake          | payload
//  in      | input     | in_valid/in_stall  | in_data  (mmpc_pkg::in_t)
//  out     | output    | out_valid/out_stall| out_data (mmpc_pkg::out_t)
//  cfg     | input     | cfg_we             | cfg_wdata (node_count)
//
//  Add commands are taken without leaving idle; a read waits in an output state while the output is stalled.
//  A clear sweeps all MAX_NODES (512) node table entries; reset runs the same sweep.
//  A solve sweeps the node table, then relaxes every stored edge in both
//  directions (skipping an edge naming a node beyond the count), repeating passes
//  until one pass changes nothing (at most about node_count + 1 passes), all
//  through one shared max/compare unit.
//  in_stall is high whenever the sequencer is not idle.
// ----------------------------------------------------------------------------
module minimax_path_costs_via_spanning_tree_core (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            in_valid,
	output logic                            in_stall,
	input  mmpc_pkg::in_t                   in_data,
	output logic                            out_valid,
	input  logic                            out_stall,
	output mmpc_pkg::out_t                  out_data,
	input  logic                            cfg_we,
	input  logic [mmpc_pkg::NCFG_BITS-1:0]  cfg_wdata
);
	import mmpc_pkg::*;

	typedef enum logic [3:0] {
		S_CLR, S_IDLE, S_SRC, S_EF, S_NF, S_UB, S_UA, S_OUT
	} state_t;

	state_t                 state_q;
	logic [NCFG_BITS-1:0]   node_count_q;
	logic [NCFG_BITS-1:0]   n_eff;
	logic [ECNT_BITS-1:0]   edge_total_q;
	logic                   drop_q;
	logic                   solve_pend_q;
	logic                   changed_q;
	logic [NODE_BITS-1:0]   sweep_q;
	logic [NODE_BITS-1:0]   src_q;
	logic [NODE_BITS-1:0]   rd_node_q;
	logic                   rd_ok_q;
	logic [EDGE_BITS-1:0]   eidx_q;
	logic                   out_valid_q;
	out_t                   out_q;

	edge_t                  edge_mem [MAX_EDGES];
	node_t                  node_mem [MAX_NODES];
	edge_t                  edge_rd_q;
	node_t                  rd_a_q;
	node_t                  rd_b_q;

	logic                   accept;
	logic                   edge_we;
	logic                   edge_bad;
	logic                   node_we;
	logic [NODE_BITS-1:0]   node_waddr;
	node_t                  node_wdata;
	logic [NODE_BITS-1:0]   addr_a;
	node_t                  rl_from;
	node_t                  rl_to;
	logic                   rl_improve;
	logic [COST_BITS-1:0]   rl_cost;
	logic                   edge_out;
	logic                   last_edge;

	// clamp node count into 1..MAX_NODES
	always_comb begin
		n_eff = node_count_q;
		if (node_count_q == '0)
			n_eff = NCFG_BITS'(1);
		else if (node_count_q > NCFG_BITS'(MAX_NODES))
			n_eff = NCFG_BITS'(MAX_NODES);
	end

	assign in_stall  = (state_q != S_IDLE);
	assign accept    = in_valid && !in_stall;
	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	assign edge_bad = (edge_total_q >= ECNT_BITS'(MAX_EDGES)) ||
		({1'b0, in_data.end_a} >= n_eff) || ({1'b0, in_data.end_b} >= n_eff);
	assign edge_we  = accept && (in_data.cmd == CMD_ADD) && !edge_bad;

	assign edge_out  = ({1'b0, edge_rd_q.a} >= n_eff) || ({1'b0, edge_rd_q.b} >= n_eff);
	assign last_edge = ({1'b0, eidx_q} + ECNT_BITS'(1)) == edge_total_q;

	// share the relax unit between both edge directions
	always_comb begin
		if (state_q == S_UA) begin
			rl_from = rd_b_q;
			rl_to   = rd_a_q;
		end else begin
			rl_from = rd_a_q;
			rl_to   = rd_b_q;
		end
	end

	mmpc_relax u_relax (
		.from_node (rl_from),
		.to_node   (rl_to),
		.edge_cost (edge_rd_q.c),
		.improve   (rl_improve),
		.new_cost  (rl_cost)
	);

	// node table write port
	always_comb begin
		node_we    = 1'b0;
		node_waddr = sweep_q;
		node_wdata = '0;
		case (state_q)
			S_CLR: begin
				node_we = 1'b1;
			end
			S_SRC: begin
				node_we    = 1'b1;
				node_waddr = src_q;
				node_wdata = '{reach: 1'b1, cost: '0};
			end
			S_UB: begin
				node_we    = rl_improve;
				node_waddr = edge_rd_q.b;
				node_wdata = '{reach: 1'b1, cost: rl_cost};
			end
			S_UA: begin
				node_we    = rl_improve;
				node_waddr = edge_rd_q.a;
				node_wdata = '{reach: 1'b1, cost: rl_cost};
			end
			default: ;
		endcase
	end

	always_comb begin
		if (state_q == S_IDLE)
			addr_a = in_data.read_node;
		else if (state_q == S_OUT)
			addr_a = rd_node_q;
		else
			addr_a = edge_rd_q.a;
	end

	// memories with registered reads
	always_ff @(posedge clk) begin
		if (edge_we)
			edge_mem[edge_total_q[EDGE_BITS-1:0]] <= '{a: in_data.end_a,
				b: in_data.end_b, c: in_data.cost};
		edge_rd_q <= edge_mem[eidx_q];
	end

	always_ff @(posedge clk) begin
		if (node_we)
			node_mem[node_waddr] <= node_wdata;
		rd_a_q <= node_mem[addr_a];
		rd_b_q <= node_mem[edge_rd_q.b];
	end

	// configuration register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			node_count_q <= NCFG_BITS'(1);
		end else if (cfg_we) begin
			node_count_q <= cfg_wdata;
		end
	end

	// sequencer and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_CLR;
			edge_total_q <= '0;
			drop_q       <= 1'b0;
			solve_pend_q <= 1'b0;
			changed_q    <= 1'b0;
			sweep_q      <= '0;
			src_q        <= '0;
			rd_node_q    <= '0;
			rd_ok_q      <= 1'b0;
			eidx_q       <= '0;
			out_valid_q  <= 1'b0;
			out_q        <= '0;
		end else begin
			// drop the result once transferred
			if (out_valid_q && !out_stall && state_q != S_OUT)
				out_valid_q <= 1'b0;
			case (state_q)
				S_CLR: begin
					sweep_q <= sweep_q + NODE_BITS'(1);
					if (sweep_q == NODE_BITS'(MAX_NODES - 1)) begin
						if (solve_pend_q && ({1'b0, src_q} < n_eff))
							state_q <= S_SRC;
						else
							state_q <= S_IDLE;
						solve_pend_q <= 1'b0;
					end
				end
				S_IDLE: begin
					if (accept) begin
						case (in_data.cmd)
							CMD_CLEAR: begin
								edge_total_q <= '0;
								drop_q       <= 1'b0;
								sweep_q      <= '0;
								state_q      <= S_CLR;
							end
							CMD_ADD: begin
								if (edge_bad)
									drop_q <= 1'b1;
								else
									edge_total_q <= edge_total_q + ECNT_BITS'(1);
							end
							CMD_SOLVE: begin
								src_q        <= in_data.source_node;
								solve_pend_q <= 1'b1;
								sweep_q      <= '0;
								state_q      <= S_CLR;
							end
							default: begin
								rd_node_q <= in_data.read_node;
								rd_ok_q   <= ({1'b0, in_data.read_node} < n_eff);
								state_q   <= S_OUT;
							end
						endcase
					end
				end
				S_SRC: begin
					eidx_q    <= '0;
					changed_q <= 1'b0;
					state_q   <= (edge_total_q == '0) ? S_IDLE : S_EF;
				end
				S_EF: begin
					state_q <= S_NF;
				end
				S_NF: begin
					// skip edges naming nodes beyond the current count
					if (!edge_out)
						state_q <= S_UB;
					else if (last_edge) begin
						eidx_q    <= '0;
						changed_q <= 1'b0;
						state_q   <= changed_q ? S_EF : S_IDLE;
					end else begin
						eidx_q  <= eidx_q + EDGE_BITS'(1);
						state_q <= S_EF;
					end
				end
				S_UB: begin
					if (rl_improve)
						changed_q <= 1'b1;
					state_q <= S_UA;
				end
				S_UA: begin
					if (last_edge) begin
						eidx_q    <= '0;
						changed_q <= 1'b0;
						state_q   <= (changed_q || rl_improve) ? S_EF : S_IDLE;
					end else begin
						if (rl_improve)
							changed_q <= 1'b1;
						eidx_q  <= eidx_q + EDGE_BITS'(1);
						state_q <= S_EF;
					end
				end
				S_OUT: begin
					// hold until the output register is free
					if (!out_valid_q || !out_stall) begin
						out_valid_q           <= 1'b1;
						out_q.node_index      <= rd_node_q;
						out_q.reachable       <= rd_ok_q && rd_a_q.reach;
						out_q.bottleneck_cost <= (rd_ok_q && rd_a_q.reach) ?
							rd_a_q.cost : '0;
						out_q.edge_error      <= drop_q;
						state_q               <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule

// ----- hdl/mmpc_checker.sv -----
// ----------------------------------------------------------------------------
// mmpc_checker
// Port-level checks of the minimax path cost core, bound to the top level.
// ----------------------------------------------------------------------------
module mmpc_checker (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	input  logic            in_stall,
	input  mmpc_pkg::in_t   in_data,
	input  logic            out_valid,
	input  logic            out_stall,
	input  mmpc_pkg::out_t  out_data
);
	import mmpc_pkg::*;

	// a stalled result stays offered
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid)
		else $error("result withdrawn while stalled");

	// unreachable nodes report zero cost
	a_unreach_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_data.reachable |-> out_data.bottleneck_cost == '0)
		else $error("unreachable node with nonzero cost");

	// a solve keeps the input stalled on the next cycle
	a_solve_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall && in_data.cmd == CMD_SOLVE |=> in_stall)
		else $error("input taken right after solve");

	// a read keeps the input stalled on the next cycle
	a_read_lat: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall && in_data.cmd == CMD_READ |=> in_stall)
		else $error("input taken right after read");

endmodule

bind minimax_path_costs_via_spanning_tree_core mmpc_checker u_mmpc_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_valid),
	.in_stall  (in_stall),
	.in_data   (in_data),
	.out_valid (out_valid),
	.out_stall (out_stall),
	.out_data  (out_data)
);

// ----- sim/minimax_path_costs_via_spanning_tree_core_test.sv -----
// ----------------------------------------------------------------------------
// minimax_path_costs_via_spanning_tree_core_test
// Self-checking regression of the minimax path cost core. A directed table
// covers reset, clamping, dropped edges, self loops and out-of-range nodes.
// Random graph sessions follow, each of them config, mostly a clear, edge
// loads, a solve and reads. Every read result is checked against a
// bottleneck-path predictor or, in the directed table, a typed expectation.
// ----------------------------------------------------------------------------
module minimax_path_costs_via_spanning_tree_core_test;
	import mmpc_pkg::*;

	logic clk;
	logic arst_n;
	logic in_valid;
	logic in_stall;
	in_t in_data;
	logic out_valid;
	logic out_stall;
	out_t out_data;
	logic cfg_we;
	logic [NCFG_BITS-1:0] cfg_wdata;

	minimax_path_costs_via_spanning_tree_core DUT (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
		.out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
		.cfg_we(cfg_we), .cfg_wdata(cfg_wdata)
	);

	// stimulus row: typed expectation only where it is obvious
	typedef struct {
		bit             set_cfg;
		logic [9:0]     cfg_val;
		in_t            item;
		bit             has_exp;
		out_t           exp;
	} row_t;

	typedef struct {
		bit   has_exp;
		out_t exp;
	} tag_t;

	// predictor state
	logic [9:0]     node_cfg;
	edge_t          edge_list[$];
	bit             drop_seen;
	bit             reach_map[MAX_NODES];
	logic [15:0]    cost_map[MAX_NODES];

	out_t  pending_reads[$];
	tag_t  item_tags[$];
	int    fails;
	bit    quiet;
	int    hold_asked;
	int    hold_done;
	int    hold_left;

	// clock
	always begin
		clk = 1'b1; #10;
		clk = 1'b0; #10;
	end

	function automatic int nodes_active();
		if (node_cfg < 1) return 1;
		if (node_cfg > MAX_NODES) return MAX_NODES;
		return node_cfg;
	endfunction

	// minimax cost from the source by repeated max-relaxation over all edges
	task automatic solve_bottleneck(input logic [8:0] src);
		int n;
		bit changed;
		logic [15:0] via;
		n = nodes_active();
		for (int i = 0; i < MAX_NODES; i++) begin
			reach_map[i] = 0;
			cost_map[i] = '0;
		end
		if (src >= n) return;
		reach_map[src] = 1;
		changed = 1;
		while (changed) begin
			changed = 0;
			foreach (edge_list[k]) begin
				if (edge_list[k].a < n && edge_list[k].b < n) begin
					if (reach_map[edge_list[k].a]) begin
						via = cost_map[edge_list[k].a] > edge_list[k].c ?
							cost_map[edge_list[k].a] : edge_list[k].c;
						if (!reach_map[edge_list[k].b] || via < cost_map[edge_list[k].b]) begin
							reach_map[edge_list[k].b] = 1;
							cost_map[edge_list[k].b] = via;
							changed = 1;
						end
					end
					if (reach_map[edge_list[k].b]) begin
						via = cost_map[edge_list[k].b] > edge_list[k].c ?
							cost_map[edge_list[k].b] : edge_list[k].c;
						if (!reach_map[edge_list[k].a] || via < cost_map[edge_list[k].a]) begin
							reach_map[edge_list[k].a] = 1;
							cost_map[edge_list[k].a] = via;
							changed = 1;
						end
					end
				end
			end
		end
		cost_map[src] = '0;
	endtask

	// advance the predictor by one accepted item
	task automatic predict_item(input in_t d, input tag_t tg);
		int n;
		edge_t e;
		out_t r;
		n = nodes_active();
		case (cmd_t'(d.cmd))
			CMD_CLEAR: begin
				edge_list.delete();
				drop_seen = 0;
				for (int i = 0; i < MAX_NODES; i++) reach_map[i] = 0;
			end
			CMD_ADD: begin
				if (edge_list.size() >= MAX_EDGES || d.end_a >= n || d.end_b >= n) begin
					drop_seen = 1;
				end else begin
					e.a = d.end_a; e.b = d.end_b; e.c = d.cost;
					edge_list.insert(edge_list.size(), e);
				end
			end
			CMD_SOLVE: solve_bottleneck(d.source_node);
			default: begin
				r.node_index = d.read_node;
				r.reachable = d.read_node < n && reach_map[d.read_node];
				r.bottleneck_cost = r.reachable ? cost_map[d.read_node] : '0;
				r.edge_error = drop_seen;
				pending_reads.insert(pending_reads.size(), tg.has_exp ? tg.exp : r);
			end
		endcase
	endtask

	// monitor both channels
	always @(posedge clk) begin
		out_t x;
		tag_t tg;
		if (arst_n) begin
			if (out_valid && !out_stall) begin
				if (pending_reads.size() == 0) begin
					$display("%0t: unexpected result %p", $realtime, out_data);
					fails++;
				end else begin
					x = pending_reads.pop_front();
					if (out_data !== x) begin
						$display("%0t: mismatch expected %p actual %p", $realtime, x, out_data);
						fails++;
					end
				end
			end
			if (in_valid && !in_stall) begin
				tg = item_tags.pop_front();
				predict_item(in_data, tg);
			end
		end
	end

	// receiver: random stall plus a long hold-off on request
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_stall <= 1'b0;
			hold_left <= 0;
			hold_done <= 0;
		end else if (hold_done != hold_asked) begin
			hold_done <= hold_asked;
			hold_left <= 400;
			out_stall <= 1'b1;
		end else if (hold_left > 0) begin
			hold_left <= hold_left - 1;
			out_stall <= 1'b1;
		end else begin
			out_stall <= !quiet && $urandom_range(99) < 17;
		end
	end

	// offer one item and hold it until transfer
	task automatic send_item(input in_t d, input bit has_exp, input out_t exp);
		tag_t tg;
		tg.has_exp = has_exp;
		tg.exp = exp;
		while (!quiet && $urandom_range(99) < 17) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		item_tags.insert(item_tags.size(), tg);
		in_valid <= 1'b1;
		in_data <= d;
		forever begin
			@(negedge clk);
			if (!in_stall) break;
		end
		@(posedge clk);
	endtask

	// write node_count once the block is idle
	task automatic write_nodes(input logic [9:0] v);
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending_reads.size() || item_tags.size()) @(posedge clk);
		repeat (8) @(posedge clk);
		forever begin
			@(negedge clk);
			if (!in_stall) break;
		end
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_wdata <= v;
		@(posedge clk);
		node_cfg = v;
		cfg_we <= 1'b0;
	endtask

	function automatic in_t make_item(input cmd_t c, input int a, input int b,
		input int w, input int s, input int r);
		in_t d;
		logic [63:0] raw;
		raw = {$urandom, $urandom};
		d = raw[$bits(in_t)-1:0];
		d.cmd = c;
		d.end_a = NODE_BITS'(a); d.end_b = NODE_BITS'(b); d.cost = COST_BITS'(w);
		d.source_node = NODE_BITS'(s); d.read_node = NODE_BITS'(r);
		return d;
	endfunction

	function automatic out_t mk_out(input int idx, input int c, input bit rch, input bit err);
		out_t o;
		o.node_index = NODE_BITS'(idx); o.bottleneck_cost = COST_BITS'(c);
		o.reachable = rch; o.edge_error = err;
		return o;
	endfunction

	function automatic row_t mk_row(input bit sc, input int cv, input in_t d,
		input bit he, input out_t e);
		row_t r;
		r.set_cfg = sc; r.cfg_val = NCFG_BITS'(cv); r.item = d; r.has_exp = he; r.exp = e;
		return r;
	endfunction

	// main stimulus
	initial begin
		row_t steps[$];
		out_t none;
		int n, k, src;
		int x, y;
		none = '0;
		fails = 0;
		quiet = 0;
		hold_asked = 0;
		node_cfg = 1;
		drop_seen = 0;
		for (int i = 0; i < MAX_NODES; i++) begin
			reach_map[i] = 0;
			cost_map[i] = '0;
		end
		arst_n = 1'b0;
		in_valid <= 1'b0;
		in_data <= '0;
		cfg_we <= 1'b0;
		cfg_wdata <= '0;
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(posedge clk);

		// directed table
		steps = {steps, mk_row(0, 0, make_item(CMD_READ, 0, 0, 0, 0, 0), 1, mk_out(0, 0, 0, 0))};
		steps = {steps, mk_row(1, 8, make_item(CMD_ADD, 0, 1, 5, 0, 0), 0, none)};
		steps = {steps, mk_row(0, 0, make_item(CMD_ADD, 1, 2, 65535, 0, 0), 0, none)};
		steps = {steps, mk_row(0, 0, make_item(CMD_ADD, 2, 3, 0, 0, 0), 0, none)};
		steps = {steps, mk_row(0, 0, make_item(CMD_ADD, 3, 3, 7, 0, 0), 0, none)};
		steps = {steps, mk_row(0, 0, make_item(CMD_ADD, 0, 9, 1, 0, 0), 0, none)};
		steps = {steps, mk_row(0, 0, make_item(CMD_ADD, 4, 5, 3, 0, 0), 0, none)};
		steps = {steps, mk_row(0, 0, make_item(CMD_ADD, 0, 2, 65535, 0, 0), 0, none)};
		steps = {steps, mk_row(0, 0, make_item(CMD_SOLVE, 0, 0, 0, 0, 0), 0, none)};
		steps = {steps, mk_row(0, 0, make_item(CMD_READ, 0, 0, 0, 0, 0), 1, mk_out(0, 0, 1, 1))};
		steps = {steps, mk_row(0, 0, make_item(CMD_READ, 0, 0, 0, 0, 2), 0, none)};
		steps = {steps, mk_row(0, 0, make_item(CMD_READ, 0, 0, 0, 0, 3), 0, none)};
		steps = {steps, mk_row(0, 0, make_item(CMD_READ, 0, 0, 0, 0, 4), 1, mk_out(4, 0, 0, 1))};
		steps = {steps, mk_row(0, 0, make_item(CMD_READ, 0, 0, 0, 0, 511),
			1, mk_out(511, 0, 0, 1))};
		steps = {steps, mk_row(0, 0, make_item(CMD_SOLVE, 0, 0, 0, 9, 0), 0, none)};
		steps = {steps, mk_row(0, 0, make_item(CMD_READ, 0, 0, 0, 0, 0), 1, mk_out(0, 0, 0, 1))};
		steps = {steps, mk_row(1, 3, make_item(CMD_SOLVE, 0, 0, 0, 0, 0), 0, none)};
		steps = {steps, mk_row(0, 0, make_item(CMD_READ, 0, 0, 0, 0, 2), 0, none)};
		steps = {steps, mk_row(0, 0, make_item(CMD_READ, 0, 0, 0, 0, 3), 1, mk_out(3, 0, 0, 1))};
		steps = {steps, mk_row(0, 0, make_item(CMD_CLEAR, 0, 0, 0, 0, 0), 0, none)};
		steps = {steps, mk_row(0, 0, make_item(CMD_READ, 0, 0, 0, 0, 1), 1, mk_out(1, 0, 0, 0))};
		steps = {steps, mk_row(1, 0, make_item(CMD_ADD, 0, 0, 1, 0, 0), 0, none)};
		steps = {steps, mk_row(0, 0, make_item(CMD_SOLVE, 0, 0, 0, 0, 0), 0, none)};
		steps = {steps, mk_row(0, 0, make_item(CMD_READ, 0, 0, 0, 0, 0), 1, mk_out(0, 0, 1, 0))};
		steps = {steps, mk_row(1, 1023, make_item(CMD_ADD, 511, 0, 65535, 0, 0), 0, none)};
		steps = {steps, mk_row(0, 0, make_item(CMD_SOLVE, 0, 0, 0, 511, 0), 0, none)};
		steps = {steps, mk_row(0, 0, make_item(CMD_READ, 0, 0, 0, 0, 0), 0, none)};
		foreach (steps[i]) begin
			if (steps[i].set_cfg) write_nodes(steps[i].cfg_val);
			send_item(steps[i].item, steps[i].has_exp, steps[i].exp);
		end

		// random graph sessions
		for (int g = 0; g < 21; g++) begin
			quiet = (g >= 6 && g < 9);
			case ($urandom_range(9))
				0: n = 1;
				1: n = $urandom_range(1, 0) ? 512 : 1023;
				2: n = 0;
				default: n = $urandom_range(12, 2);
			endcase
			write_nodes(NCFG_BITS'(n));
			n = nodes_active();
			if ($urandom_range(9) < 8)
				send_item(make_item(CMD_CLEAR, 0, 0, 0, 0, 0), 0, none);
			k = $urandom_range(20);
			for (int i = 0; i < k; i++) begin
				x = $urandom_range(n - 1);
				y = $urandom_range(n - 1);
				if ($urandom_range(9) == 0) x = $urandom_range(511);
				if ($urandom_range(9) == 0) y = $urandom_range(511);
				send_item(make_item(CMD_ADD, x, y,
					$urandom_range(1) ? $urandom_range(65535) : $urandom_range(3), 0, 0),
					0, none);
			end
			src = $urandom_range(5) == 0 ? $urandom_range(511) : $urandom_range(n - 1);
			send_item(make_item(CMD_SOLVE, 0, 0, 0, src, 0), 0, none);
			// hold off the receiver so the block fills and stalls its input
			if (g == 12) hold_asked = hold_asked + 1;
			for (int i = 0; i < (g == 12 ? 20 : 8); i++) begin
				y = $urandom_range(5) == 0 ? $urandom_range(511) : $urandom_range(n - 1);
				send_item(make_item(CMD_READ, 0, 0, 0, 0, y), 0, none);
			end
		end

		// drain and finish
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending_reads.size() || item_tags.size()) @(posedge clk);
		repeat (50) @(posedge clk);
		if (fails == 0 && pending_reads.size() == 0)
			$display("minimax_path_costs_via_spanning_tree_core regression: pass");
		else
			$display("minimax_path_costs_via_spanning_tree_core regression: fail");
		$finish;
	end

	// run limit
	initial begin
		#60000000;
		$display("minimax_path_costs_via_spanning_tree_core regression: fail");
		$finish;
	end

endmodule
